FILE: sv/lrss_pkg.sv
// Shared types and constants for the life rule stencil stream block.
package lrss_pkg;

   localparam int CFG_WIDTH = 9;
   localparam int POS_OUT_WIDTH = 8;
   localparam int DEF_MAX_COLS = 256;
   localparam int DEF_MAX_ROWS = 256;
   localparam logic [CFG_WIDTH-1:0] DIM_RESET = 9'd256;

   typedef enum logic [0:0] {
      CSR_ROWS_IN_USE = 1'b0,
      CSR_COLS_IN_USE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic cell_alive;
      logic frame_start;
   } req_item_type;

   typedef struct packed {
      logic                     next_alive;
      logic [POS_OUT_WIDTH-1:0] cell_row;
      logic [POS_OUT_WIDTH-1:0] cell_col;
      logic                     frame_last;
   } rsp_item_type;

   typedef struct packed {
      logic two_above;
      logic one_above;
   } line_pair_type;

endpackage

FILE: sv/lrss_line_mem.sv
// Line store memory: both rows above share one entry per padded column.
module lrss_line_mem #(
   parameter int DEPTH = 258,
   parameter int AW = 9
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  lrss_pkg::line_pair_type wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output lrss_pkg::line_pair_type rd_data
);
   import lrss_pkg::*;

   line_pair_type mem_ff [DEPTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lrss_pos.sv
// Padded raster position tracker with frame start and wrap handling.
module lrss_pos #(
   parameter int CW = 9,
   parameter int RW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          frame_start,
   input  logic [CW-1:0] pw,
   input  logic [RW-1:0] ph,
   output logic [RW-1:0] cur_row,
   output logic [CW-1:0] cur_col,
   output logic          emit,
   output logic          last
);
   import lrss_pkg::*;

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] r0;
   logic [CW-1:0] c0;

   always_comb begin
      r0 = frame_start ? '0 : row_ff;
      c0 = frame_start ? '0 : col_ff;
      if (c0 >= pw) begin
         c0 = '0;
         r0 = r0 + RW'(1);
      end
      if (r0 >= ph) begin
         r0 = '0;
      end
      row_in = r0;
      col_in = c0 + CW'(1);
      if (col_in >= pw) begin
         col_in = '0;
         row_in = r0 + RW'(1);
         if (row_in >= ph) begin
            row_in = '0;
         end
      end
   end

   assign cur_row = r0;
   assign cur_col = c0;
   assign emit = (r0 >= RW'(2)) && (c0 >= CW'(2));
   assign last = (r0 == ph - RW'(1)) && (c0 == pw - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

FILE: sv/lrss_window.sv
// Three by three window shift register and the B3/S23 rule.
module lrss_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  lrss_pkg::line_pair_type above,
   input  logic                    cur_cell,
   output logic                    next_alive
);
   import lrss_pkg::*;

   logic [8:0] window_ff, window_in;
   logic [3:0] total;
   logic [3:0] neighbors;
   logic       center;

   always_comb begin
      window_in = {cur_cell, above.one_above, above.two_above, window_ff[8:3]};
      total = '0;
      for (int i = 0; i < 9; i++) begin
         total = total + 4'(window_in[i]);
      end
      center = window_in[4];
      neighbors = total - 4'(center);
      if (center) begin
         next_alive = (neighbors == 4'd2) || (neighbors == 4'd3);
      end else begin
         next_alive = (neighbors == 4'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (fire) begin
         window_ff <= window_in;
      end
   end

endmodule

FILE: sv/life_rule_stencil_stream.sv
// Top level of the life rule stencil stream block.
//
// Computes one B3/S23 generation over a halo-padded grid that arrives on the
// req channel one cell per item in raster order, (rows+2) by (cols+2) cells.
// Each item whose padded position completes the neighborhood of an interior
// cell gives one rsp item with that cell's next state, its interior row and
// column, and frame_last on the final interior cell. Other items give none.
// The csr channel writes rows_in_use and cols_in_use; it is always ready and
// should be used only while the block is idle.
// An accepted item passes from the read stage registers into the rsp output
// register, which drives rsp_valid and rsp_item.
// Throughput: one item per cycle while rsp is not stalled, set by the single
// line store memory, read for one item while the previous item writes back.
// When rsp_stall holds a result, the one item behind it waits in the read
// stage and req_stall rises until the result is taken.
// Reset clears the position, the window, the registers to 256 by 256 and all
// valid flags. The line stores are not cleared; an entry read before its
// first write only feeds the halo rows at the top of a frame.
module life_rule_stencil_stream #(
   parameter int MAX_COLS = lrss_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = lrss_pkg::DEF_MAX_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lrss_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lrss_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  lrss_pkg::csr_index_type             csr_index,
   input  logic [lrss_pkg::CFG_WIDTH-1:0]      csr_data
);
   import lrss_pkg::*;

   localparam int DEPTH = MAX_COLS + 2;
   localparam int AW = $clog2(MAX_COLS + 2);
   localparam int CW = $clog2(MAX_COLS + 3);
   localparam int RW = $clog2(MAX_ROWS + 3);

   logic [CFG_WIDTH-1:0] rows_ff;
   logic [CFG_WIDTH-1:0] cols_ff;
   logic [CW-1:0]        cols_eff;
   logic [RW-1:0]        rows_eff;
   logic [CW-1:0]        pw;
   logic [RW-1:0]        ph;

   logic          accept;
   logic          out_free;
   logic          s1_fire;
   logic [RW-1:0] cur_row;
   logic [CW-1:0] cur_col;
   logic          cur_emit;
   logic          cur_last;

   logic          s1_valid_ff;
   logic          s1_cell_ff;
   logic [RW-1:0] s1_row_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;
   logic          fwd_ff;
   line_pair_type fwd_data_ff;

   line_pair_type mem_rd;
   line_pair_type above;
   line_pair_type wr_data;
   logic          next_alive;

   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;
   rsp_item_type  rsp_item_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_RESET;
         cols_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: rows_ff <= csr_data;
            CSR_COLS_IN_USE: cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(cols_ff);
      end
      if (rows_ff == '0) begin
         rows_eff = RW'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(rows_ff);
      end
   end

   assign pw = cols_eff + CW'(2);
   assign ph = rows_eff + RW'(2);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_fire = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept = req_valid && !req_stall;

   lrss_pos #(
      .CW(CW),
      .RW(RW)
   ) u_pos (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .frame_start(req_item.frame_start),
      .pw         (pw),
      .ph         (ph),
      .cur_row    (cur_row),
      .cur_col    (cur_col),
      .emit       (cur_emit),
      .last       (cur_last)
   );

   lrss_line_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_line_mem (
      .clock  (clock),
      .wr_en  (s1_fire),
      .wr_addr(s1_col_ff[AW-1:0]),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(cur_col[AW-1:0]),
      .rd_data(mem_rd)
   );

   assign above = fwd_ff ? fwd_data_ff : mem_rd;
   assign wr_data.two_above = above.one_above;
   assign wr_data.one_above = s1_cell_ff;

   lrss_window u_window (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .above     (above),
      .cur_cell  (s1_cell_ff),
      .next_alive(next_alive)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         fwd_ff <= s1_fire && (s1_col_ff == cur_col);
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff <= req_item.cell_alive;
         s1_row_ff <= cur_row;
         s1_col_ff <= cur_col;
         s1_emit_ff <= cur_emit;
         s1_last_ff <= cur_last;
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      rsp_item_in.next_alive = next_alive;
      rsp_item_in.cell_row = POS_OUT_WIDTH'(s1_row_ff - RW'(2));
      rsp_item_in.cell_col = POS_OUT_WIDTH'(s1_col_ff - CW'(2));
      rsp_item_in.frame_last = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("read stage lost its item while the output was stalled");

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> (cur_col < pw) && (cur_row < ph))
      else $error("position outside the padded frame");

   a_emit_interior: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_emit_ff |-> (s1_col_ff >= CW'(2)) && (s1_row_ff >= RW'(2)))
      else $error("result flagged for a halo cell");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");
`endif

endmodule

FILE: verif/life_rule_stencil_stream_tb.sv
// Self-checking testbench for the life rule stencil stream block.
`timescale 1ns / 100ps

module life_rule_stencil_stream_tb;
   import lrss_pkg::*;

   localparam int LINE_DEPTH = DEF_MAX_COLS + 2;
   localparam int LONG_HOLD_CYCLES = 200;

   typedef enum int {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   class next_gen_tracker;
      bit                   line_one [0:LINE_DEPTH-1];
      bit                   line_two [0:LINE_DEPTH-1];
      bit [8:0]             window;
      int                   row_pos;
      int                   col_pos;
      logic [CFG_WIDTH-1:0] rows_reg;
      logic [CFG_WIDTH-1:0] cols_reg;
      rsp_item_type         awaiting[$];
      int                   mismatches;

      function new();
         window = '0;
         row_pos = 0;
         col_pos = 0;
         rows_reg = DIM_RESET;
         cols_reg = DIM_RESET;
         mismatches = 0;
      endfunction

      function int clamp_dim(logic [CFG_WIDTH-1:0] v, int maxv);
         if (v == 0) return 1;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function int padded_width();
         return clamp_dim(cols_reg, DEF_MAX_COLS) + 2;
      endfunction

      function int padded_height();
         return clamp_dim(rows_reg, DEF_MAX_ROWS) + 2;
      endfunction

      function int pending();
         return awaiting.size();
      endfunction

      function void write_reg(csr_index_type idx, logic [CFG_WIDTH-1:0] data);
         case (idx)
            CSR_ROWS_IN_USE: rows_reg = data;
            CSR_COLS_IN_USE: cols_reg = data;
            default: ;
         endcase
      endfunction

      // Advances the window by one padded cell and queues the interior result it completes.
      function void take_cell(req_item_type it);
         int           pw;
         int           ph;
         int           pr;
         int           pc;
         int           nb;
         bit           a1;
         bit           a2;
         bit           center;
         rsp_item_type res;
         pw = padded_width();
         ph = padded_height();
         if (it.frame_start) begin
            row_pos = 0;
            col_pos = 0;
         end
         if (col_pos >= pw) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= ph) row_pos = 0;
         pr = row_pos;
         pc = col_pos;
         a1 = line_one[pc];
         a2 = line_two[pc];
         line_two[pc] = a1;
         line_one[pc] = it.cell_alive;
         window = {it.cell_alive, a1, a2, window[8:3]};
         if (pr >= 2 && pc >= 2) begin
            center = window[4];
            nb = $countones(window) - center;
            res.next_alive = center ? (nb == 2 || nb == 3) : (nb == 3);
            res.cell_row = 8'(pr - 2);
            res.cell_col = 8'(pc - 2);
            res.frame_last = (pr - 2 == ph - 3) && (pc - 2 == pw - 3);
            awaiting.push_back(res);
         end
         col_pos = pc + 1;
         if (col_pos >= pw) begin
            col_pos = 0;
            row_pos = pr + 1;
            if (row_pos >= ph) row_pos = 0;
         end
      endfunction

      function void match_result(rsp_item_type got);
         rsp_item_type want;
         if (awaiting.size() == 0) begin
            $error("unexpected result at row %0d col %0d", got.cell_row, got.cell_col);
            mismatches++;
            return;
         end
         want = awaiting.pop_front();
         if (got.next_alive !== want.next_alive) begin
            $error("next_alive: expected %0d, got %0d", want.next_alive, got.next_alive);
            mismatches++;
         end
         if (got.cell_row !== want.cell_row) begin
            $error("cell_row: expected %0d, got %0d", want.cell_row, got.cell_row);
            mismatches++;
         end
         if (got.cell_col !== want.cell_col) begin
            $error("cell_col: expected %0d, got %0d", want.cell_col, got.cell_col);
            mismatches++;
         end
         if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_ROWS_IN_USE;
   logic [CFG_WIDTH-1:0] csr_data = '0;

   next_gen_tracker tracker;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              cells_sent = 0;
   bit              long_hold_req = 1'b0;

   life_rule_stencil_stream dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : rsp_stall_gen
      int hold_cycles;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cycles = LONG_HOLD_CYCLES;
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) tracker.match_result(rsp_item);
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SEND: begin
            send_idle_pct = 47;
            recv_stall_pct = 0;
         end
         IDLE_RECV: begin
            send_idle_pct = 0;
            recv_stall_pct = 47;
         end
         default: begin
            send_idle_pct = 21;
            recv_stall_pct = 21;
         end
      endcase
   endtask

   task automatic send_cell(input logic alive, input logic start);
      req_item_type it;
      it.cell_alive = alive;
      it.frame_start = start;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tracker.take_cell(req_item);
      cells_sent++;
   endtask

   task automatic send_frame(input int count, input int density, input bit first_start,
                             input int stray_pct);
      for (int i = 0; i < count; i++) begin
         send_cell($urandom_range(99) < density,
                   (first_start && i == 0) || ($urandom_range(99) < stray_pct));
      end
   endtask

   task automatic send_pattern(input logic [8:0] pattern, input logic mark_start);
      for (int i = 0; i < 9; i++) send_cell(pattern[i], mark_start && i == 0);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic settle();
      pause_until_drained();
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   task automatic set_dims(input logic [CFG_WIDTH-1:0] rows, input logic [CFG_WIDTH-1:0] cols);
      settle();
      write_csr(CSR_ROWS_IN_USE, rows);
      write_csr(CSR_COLS_IN_USE, cols);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase();
      int ph;
      int pw;
      int total;
      int kind;
      set_idling(idle_mode_type'($urandom_range(3)));
      case ($urandom_range(9))
         0: set_dims(0, CFG_WIDTH'($urandom_range(0, 6)));
         1: set_dims(CFG_WIDTH'($urandom_range(1, 4)), CFG_WIDTH'($urandom_range(20, 40)));
         2: set_dims(CFG_WIDTH'($urandom_range(1, 6)), 0);
         default: set_dims(CFG_WIDTH'($urandom_range(1, 6)), CFG_WIDTH'($urandom_range(1, 10)));
      endcase
      ph = tracker.padded_height();
      pw = tracker.padded_width();
      total = ph * pw;
      repeat ($urandom_range(1, 4)) begin
         kind = $urandom_range(19);
         if (kind == 0) pause_until_drained();
         if (kind < 15) send_frame(total, $urandom_range(15, 65), $urandom_range(3) != 0, 0);
         else if (kind < 17) send_frame($urandom_range(1, total - 1), 50, 1'b1, 0);
         else if (kind < 19) send_frame($urandom_range(1, pw), 50, 1'b0, 0);
         else send_frame(total, 50, 1'b1, 8);
      end
   endtask

   initial begin
      int random_goal;
      int drain_cycles;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(IDLE_NONE);

      // Two full-width rows after reset write every line store entry.
      send_frame(2 * LINE_DEPTH + 12, 50, 1'b1, 0);
      // Shrinking mid-frame pushes the column past the width.
      set_idling(IDLE_SEND);
      set_dims(2, 5);
      send_frame(3 * 4 * 7, 40, 1'b0, 0);

      // Zero registers act as one: single-cell frames for the birth and survival rules.
      set_idling(IDLE_RECV);
      set_dims(0, 0);
      send_pattern(9'b111_111_111, 1'b1);
      send_pattern(9'b000_000_111, 1'b0);
      send_frame(4, 50, 1'b1, 0);
      send_pattern(9'b100_010_001, 1'b1);

      set_idling(IDLE_BOTH);
      set_dims(511, 1);
      send_frame(3 * 20, 35, 1'b1, 0);
      set_dims(1, 300);
      send_frame(2 * LINE_DEPTH + 12, 35, 1'b1, 0);

      // Growing the width mid-frame once every line store entry holds a written value.
      set_dims(3, 2);
      send_frame(14, 50, 1'b1, 0);
      set_dims(4, 9);
      send_frame(6 * 11 + 5, 40, 1'b0, 0);

      // The receiver holds off long enough for the block to back up into the sender.
      set_dims(4, 8);
      long_hold_req = 1'b1;
      send_frame(6 * 10, 45, 1'b1, 0);

      random_goal = 1600;
      while (cells_sent < random_goal) random_phase();

      req_valid <= 1'b0;
      drain_cycles = 0;
      while (tracker.pending() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("%0d expected results never arrived", tracker.pending());
         tracker.mismatches++;
      end
      if (tracker.mismatches == 0) begin
         $display("life_rule_stencil_stream_tb OK");
      end else begin
         $display("life_rule_stencil_stream_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("life_rule_stencil_stream_tb NOT OK");
      $finish;
   end

endmodule
